// File: rtl/selective_repeat_receiver_window_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the selective-repeat receiver window
// Shared property forms, all clocked on clock and held off during reset.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication.
`define SRRW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/srrw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srrw_pkg
// Types and constants shared by the receiver window modules.
// ---------------------------------------------------------------------------
package srrw_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int SEQ_W      = 32;
   localparam int CFG_W      = 7;
   localparam int WS_W       = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SAT_W      = (CFG_W > WS_W) ? CFG_W : WS_W;
   localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);

   typedef enum logic [1:0] {
      PKT_START = 2'd0,
      PKT_END   = 2'd1,
      PKT_DATA  = 2'd2,
      PKT_OTHER = 2'd3
   } pkt_type_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_CHECKSUM = 3'd1,
      ST_REDUNDANT    = 3'd2,
      ST_END_MISMATCH = 3'd3,
      ST_NO_START     = 3'd4,
      ST_UNKNOWN      = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EVAL = 4'b0010,
      S_SCAN = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   // Command from the sequencer to the window unit.
   typedef struct packed {
      logic             clear;
      logic             mark;
      logic [IDX_W-1:0] mark_idx;
      logic             step;
   } win_cmd_type;

endpackage

// File: rtl/srrw_window.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srrw_window
// Received bitmap and window base; slides by one slot per step.
// ---------------------------------------------------------------------------
module srrw_window (
   input  logic                              clock,
   input  logic                              reset,
   input  srrw_pkg::win_cmd_type             cmd,
   input  logic [srrw_pkg::IDX_W-1:0]        rd_idx,
   output logic [srrw_pkg::SEQ_W-1:0]        base,
   output logic                              rd_bit,
   output logic                              head_bit
);

   logic [srrw_pkg::WINDOW_MAX-1:0] map_ff, map_in;
   logic [srrw_pkg::SEQ_W-1:0]      base_ff, base_in;

   always_comb begin
      map_in  = map_ff;
      base_in = base_ff;
      if (cmd.clear) begin
         map_in  = '0;
         base_in = '0;
      end else if (cmd.step) begin
         // advance one slot, zero fill the top
         map_in  = map_ff >> 1;
         base_in = base_ff + srrw_pkg::SEQ_W'(1);
      end else if (cmd.mark) begin
         map_in[cmd.mark_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff  <= '0;
         base_ff <= '0;
      end else begin
         map_ff  <= map_in;
         base_ff <= base_in;
      end
   end

   assign base     = base_ff;
   assign rd_bit   = map_ff[rd_idx];
   assign head_bit = map_ff[0];

endmodule

// File: rtl/selective_repeat_receiver_window_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_repeat_receiver_window_top
// Receive window of a selective-repeat reliable-datagram receiver.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  carries one received packet header per request: sequence number
//          in tdata, packet type and checksum verdict in tuser.
//   rsp_*  returns one result per request: ACK number and chunk index in
//          tdata, ACK/store flags and status in tuser, tlast marks the END
//          that closed the session.
//   csr_*  writes the window size; write it only while no request is open.
// Timing: a request is evaluated the cycle after it is taken. A DATA header
//   at the window base then walks the window one slot per cycle through the
//   bitmap shift unit, past each leading received slot up to the window
//   size. The result then waits in the emit state for the output register.
//   req_tready is high only while the sequencer is idle.
// Reset: clears the session, the window base and the bitmap, and sets the
//   window size to 64.
// Stall: a finished result waits in the output register; the next request
//   is still taken and evaluated, and its result holds until the slot frees.
// ---------------------------------------------------------------------------
`include "selective_repeat_receiver_window_top_defines.svh"

module selective_repeat_receiver_window_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seq_num
   input  logic [2:0]  req_tuser,   // [1:0] pkt_type, [2] checksum_ok
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] ack_seq, [63:32] chunk_index
   output logic [4:0]  rsp_tuser,   // [0] ack_flag, [1] store_chunk, [4:2] status
   output logic        rsp_tlast,   // transfer_done
   // window size register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int SEQ_W = srrw_pkg::SEQ_W;
   localparam int WS_W  = srrw_pkg::WS_W;
   localparam int IDX_W = srrw_pkg::IDX_W;
   localparam int SAT_W = srrw_pkg::SAT_W;

   srrw_pkg::state_type state_ff, state_in;

   // configuration
   logic [srrw_pkg::CFG_W-1:0] win_size_ff, win_size_in;
   logic [WS_W-1:0]            ws;

   // session
   logic             open_ff, open_in;
   logic [SEQ_W-1:0] sid_ff, sid_in;

   // captured request (payload, no reset)
   logic [SEQ_W-1:0]           seq_ff, seq_in;
   srrw_pkg::pkt_type_type     type_ff, type_in;
   logic                       ok_ff, ok_in;

   // pending result
   logic                 res_ack_ff, res_ack_in;
   logic                 res_from_base_ff, res_from_base_in;
   logic                 res_store_ff, res_store_in;
   logic                 res_done_ff, res_done_in;
   srrw_pkg::status_type res_status_ff, res_status_in;

   // slide counter
   logic [WS_W-1:0] scan_cnt_ff, scan_cnt_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [4:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   // window unit
   srrw_pkg::win_cmd_type win_cmd;
   logic [SEQ_W-1:0]      base;
   logic                  rd_bit;
   logic                  head_bit;

   // offset arithmetic
   logic [SEQ_W:0]  diff;
   logic            at_base;
   logic            above_base;
   logic            off_fits;
   logic            out_free;
   logic [SEQ_W-1:0] ack_val;

   srrw_window u_window (
      .clock    (clock),
      .reset    (reset),
      .cmd      (win_cmd),
      .rd_idx   (diff[IDX_W-1:0]),
      .base     (base),
      .rd_bit   (rd_bit),
      .head_bit (head_bit)
   );

   // Saturate the window size to 1..WINDOW_MAX.
   always_comb begin
      if (win_size_ff == '0) begin
         ws = WS_W'(1);
      end else if (SAT_W'(win_size_ff) > SAT_W'(srrw_pkg::WINDOW_MAX)) begin
         ws = WS_W'(srrw_pkg::WINDOW_MAX);
      end else begin
         ws = WS_W'(win_size_ff);
      end
   end

   // One subtract gives ordering against the base and the slot offset.
   assign diff       = {1'b0, seq_ff} - {1'b0, base};
   assign at_base    = (diff == '0);
   assign above_base = !diff[SEQ_W] && !at_base;
   assign off_fits   = (diff[SEQ_W-1:WS_W] == '0) && (diff[WS_W-1:0] < ws);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ack_val  = !res_ack_ff ? '0 : (res_from_base_ff ? base : seq_ff);

   always_comb begin
      state_in         = state_ff;
      win_size_in      = win_size_ff;
      open_in          = open_ff;
      sid_in           = sid_ff;
      seq_in           = seq_ff;
      type_in          = type_ff;
      ok_in            = ok_ff;
      res_ack_in       = res_ack_ff;
      res_from_base_in = res_from_base_ff;
      res_store_in     = res_store_ff;
      res_done_in      = res_done_ff;
      res_status_in    = res_status_ff;
      scan_cnt_in      = scan_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_user_in      = rsp_user_ff;
      rsp_last_in      = rsp_last_ff;
      win_cmd          = '0;

      if (csr_wr_en) begin
         win_size_in = csr_wr_data;
      end

      case (state_ff)
         srrw_pkg::S_IDLE: begin
            if (req_tvalid) begin
               seq_in   = req_tdata;
               type_in  = srrw_pkg::pkt_type_type'(req_tuser[1:0]);
               ok_in    = req_tuser[2];
               state_in = srrw_pkg::S_EVAL;
            end
         end
         srrw_pkg::S_EVAL: begin
            res_ack_in       = 1'b0;
            res_from_base_in = 1'b0;
            res_store_in     = 1'b0;
            res_done_in      = 1'b0;
            res_status_in    = srrw_pkg::ST_OK;
            state_in         = srrw_pkg::S_EMIT;
            if (!ok_ff) begin
               res_status_in = srrw_pkg::ST_BAD_CHECKSUM;
            end else begin
               case (type_ff)
                  srrw_pkg::PKT_START: begin
                     if (open_ff) begin
                        res_status_in = srrw_pkg::ST_REDUNDANT;
                     end else begin
                        open_in    = 1'b1;
                        sid_in     = seq_ff;
                        res_ack_in = 1'b1;
                     end
                  end
                  srrw_pkg::PKT_END: begin
                     if (!open_ff || sid_ff != seq_ff) begin
                        res_status_in = srrw_pkg::ST_END_MISMATCH;
                     end else begin
                        // close the session and drop the window
                        open_in       = 1'b0;
                        win_cmd.clear = 1'b1;
                        res_ack_in    = 1'b1;
                        res_done_in   = 1'b1;
                     end
                  end
                  srrw_pkg::PKT_DATA: begin
                     if (!open_ff) begin
                        res_status_in = srrw_pkg::ST_NO_START;
                     end else begin
                        res_ack_in       = 1'b1;
                        res_from_base_in = 1'b1;
                        if (above_base) begin
                           if (off_fits && !rd_bit) begin
                              win_cmd.mark     = 1'b1;
                              win_cmd.mark_idx = diff[IDX_W-1:0];
                              res_store_in     = 1'b1;
                           end
                        end else if (at_base) begin
                           if (!head_bit) begin
                              win_cmd.mark     = 1'b1;
                              win_cmd.mark_idx = '0;
                              res_store_in     = 1'b1;
                           end
                           scan_cnt_in = '0;
                           state_in    = srrw_pkg::S_SCAN;
                        end
                     end
                  end
                  default: begin
                     res_status_in = srrw_pkg::ST_UNKNOWN;
                  end
               endcase
            end
         end
         srrw_pkg::S_SCAN: begin
            // advance past each leading received slot, one per cycle
            if (scan_cnt_ff < ws && head_bit) begin
               win_cmd.step = 1'b1;
               scan_cnt_in  = scan_cnt_ff + WS_W'(1);
            end else begin
               state_in = srrw_pkg::S_EMIT;
            end
         end
         srrw_pkg::S_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(res_store_ff ? seq_ff : '0), ack_val};
               rsp_user_in  = {res_status_ff, res_store_ff, res_ack_ff};
               rsp_last_in  = res_done_ff;
               state_in     = srrw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srrw_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srrw_pkg::S_IDLE;
         win_size_ff  <= srrw_pkg::WINDOW_RESET;
         open_ff      <= 1'b0;
         sid_ff       <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_size_ff  <= win_size_in;
         open_ff      <= open_in;
         sid_ff       <= sid_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff           <= seq_in;
      type_ff          <= type_in;
      ok_ff            <= ok_in;
      res_ack_ff       <= res_ack_in;
      res_from_base_ff <= res_from_base_in;
      res_store_ff     <= res_store_in;
      res_done_ff      <= res_done_in;
      res_status_ff    <= res_status_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_user_ff      <= rsp_user_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_tready = (state_ff == srrw_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SRRW_ASSERT_NEXT(a_accept_to_eval, req_tvalid && req_tready,
      state_ff == srrw_pkg::S_EVAL, "accepted request did not start evaluation")
   `SRRW_ASSERT_NOW(a_scan_bound, state_ff == srrw_pkg::S_SCAN,
      scan_cnt_ff <= ws, "slide count beyond window size")
   `SRRW_ASSERT_NEXT(a_step_advances_base, win_cmd.step,
      base == $past(base) + SEQ_W'(1), "window step did not advance base")
   `SRRW_ASSERT_NEXT(a_emit_waits,
      state_ff == srrw_pkg::S_EMIT && rsp_valid_ff && !rsp_tready,
      state_ff == srrw_pkg::S_EMIT && $stable(rsp_tdata), "result overwrote a stalled one")
   `SRRW_ASSERT_NOW(a_store_has_ack, rsp_valid_ff && rsp_tuser[1],
      rsp_tuser[0], "store without ack")

endmodule

// File: tb/tb_selective_repeat_receiver_window_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_selective_repeat_receiver_window_top
// Self-checking bench for the receive window. Packet headers go in on the
// request stream, and a tracker mirrors the session, window base and
// received bitmap to predict each ACK result, checking every returned
// result field by field. A directed opening covers the status codes and
// window edges. Random phases follow, each at a different window size
// (extremes included), with bursts of idling on both streams in all but the last.
// ---------------------------------------------------------------------------
module tb_selective_repeat_receiver_window_top;

   localparam int QUIET_LIMIT = 2000;   // cycles without any handshake

   typedef struct packed {
      logic                 ack_flag;
      logic [31:0]          ack_seq;
      logic                 store_chunk;
      logic [31:0]          chunk_index;
      logic                 transfer_done;
      srrw_pkg::status_type status;
   } ack_result_type;

   // Mirror of the receiver state; predicts one ACK result per header.
   class ack_tracker_type;
      bit [srrw_pkg::CFG_W-1:0]      window_cfg;
      bit                            session_open;
      bit [31:0]                     session_id;
      bit [31:0]                     window_base;
      bit [srrw_pkg::WINDOW_MAX-1:0] rcv_map;       // bit 0 is the base slot
      ack_result_type                pending_acks[$];
      int                            mismatches;

      function new();
         window_cfg   = srrw_pkg::WINDOW_RESET;
         session_open = 1'b0;
         session_id   = '0;
         window_base  = '0;
         rcv_map      = '0;
         mismatches   = 0;
      endfunction

      // Saturate the register to 1..WINDOW_MAX.
      function int unsigned used_window();
         if (window_cfg == 0) return 1;
         if (window_cfg > srrw_pkg::WINDOW_MAX) return srrw_pkg::WINDOW_MAX;
         return window_cfg;
      endfunction

      function void take_header(srrw_pkg::pkt_type_type kind, bit [31:0] seq, bit ok);
         ack_result_type r;
         int unsigned ws;
         bit [31:0]   offset;
         int unsigned run;
         r = '0;
         r.status = srrw_pkg::ST_OK;
         if (!ok) begin
            r.status = srrw_pkg::ST_BAD_CHECKSUM;
         end else begin
            case (kind)
               srrw_pkg::PKT_START: begin
                  if (session_open) begin
                     r.status = srrw_pkg::ST_REDUNDANT;
                  end else begin
                     session_open = 1'b1;
                     session_id   = seq;
                     r.ack_flag   = 1'b1;
                     r.ack_seq    = seq;
                  end
               end
               srrw_pkg::PKT_END: begin
                  if (!session_open || session_id != seq) begin
                     r.status = srrw_pkg::ST_END_MISMATCH;
                  end else begin
                     session_open    = 1'b0;
                     window_base     = '0;
                     rcv_map         = '0;
                     r.ack_flag      = 1'b1;
                     r.ack_seq       = seq;
                     r.transfer_done = 1'b1;
                  end
               end
               srrw_pkg::PKT_DATA: begin
                  if (!session_open) begin
                     r.status = srrw_pkg::ST_NO_START;
                  end else begin
                     ws = used_window();
                     r.ack_flag = 1'b1;
                     if (seq > window_base) begin
                        offset = seq - window_base;
                        if (offset < ws && !rcv_map[offset]) begin
                           rcv_map[offset] = 1'b1;
                           r.store_chunk   = 1'b1;
                           r.chunk_index   = seq;
                        end
                     end else if (seq == window_base) begin
                        if (!rcv_map[0]) begin
                           rcv_map[0]    = 1'b1;
                           r.store_chunk = 1'b1;
                           r.chunk_index = seq;
                        end
                        // slide past the leading received slots, at most one window
                        run = 0;
                        while (run < ws && rcv_map[run]) run++;
                        rcv_map     = rcv_map >> run;
                        window_base = window_base + run;
                     end
                     r.ack_seq = window_base;
                  end
               end
               default: r.status = srrw_pkg::ST_UNKNOWN;
            endcase
         end
         pending_acks.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
         mismatches++;
      endtask

      task check_ack(logic [63:0] data, logic [4:0] user, logic last);
         ack_result_type e;
         if (pending_acks.size() == 0) begin
            report_mismatch("unexpected result, tdata low", data[31:0], 32'd0);
            return;
         end
         e = pending_acks.pop_front();
         if (user[0] !== e.ack_flag) report_mismatch("ack_flag", user[0], e.ack_flag);
         if (data[31:0] !== e.ack_seq) report_mismatch("ack_seq", data[31:0], e.ack_seq);
         if (user[1] !== e.store_chunk)
            report_mismatch("store_chunk", user[1], e.store_chunk);
         if (data[63:32] !== e.chunk_index)
            report_mismatch("chunk_index", data[63:32], e.chunk_index);
         if (last !== e.transfer_done)
            report_mismatch("transfer_done", last, e.transfer_done);
         if (user[4:2] !== e.status) report_mismatch("status", user[4:2], e.status);
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [31:0] seq_num
   logic [2:0]  req_tuser   = '0;   // [1:0] pkt_type, [2] checksum_ok
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // [31:0] ack_seq, [63:32] chunk_index
   logic [4:0]  rsp_tuser;          // [0] ack_flag, [1] store_chunk, [4:2] status
   logic        rsp_tlast;          // transfer_done
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   ack_tracker_type tracker;
   bit          idle_enable = 1'b1;
   int          ready_left  = 0;
   int          quiet_cycles = 0;

   selective_repeat_receiver_window_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Check each accepted result, then pick the next ready burst.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_ack(rsp_tdata, rsp_tuser, rsp_tlast);
      if (ready_left > 0) begin
         ready_left--;
      end else if (idle_enable && $urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         ready_left = $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
         ready_left = $urandom_range(0, 19);
      end
   end

   // Abort when neither stream moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one header, hold it until taken, then note it.
   task automatic send_header(srrw_pkg::pkt_type_type kind, logic [31:0] seq, logic ok);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seq;
      req_tuser  <= {ok, kind};
      do @(posedge clock); while (!req_tready);
      tracker.take_header(kind, seq, ok);
   endtask

   // Drain all results, then write the window size.
   task automatic set_window(logic [6:0] size);
      req_tvalid <= 1'b0;
      while (tracker.pending_acks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.window_cfg = size;
   endtask

   // Mostly well-formed sessions with data near the window base, plus noise.
   task automatic run_phase(logic [6:0] size, int count);
      int unsigned            pick;
      int unsigned            ws;
      logic [31:0]            seq;
      srrw_pkg::pkt_type_type kind;
      logic                   ok;
      set_window(size);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         ok   = ($urandom_range(0, 31) != 0);
         ws   = tracker.used_window();
         kind = srrw_pkg::PKT_DATA;
         seq  = $urandom();
         if (!tracker.session_open) begin
            if (pick < 75) begin
               kind = srrw_pkg::PKT_START;
               if (pick < 40) seq = $urandom_range(0, 255);
            end else begin
               kind = srrw_pkg::pkt_type_type'($urandom_range(0, 3));
            end
         end else if (pick < 70) begin
            if (pick < 25)
               seq = tracker.window_base;
            else if (pick < 45)
               seq = tracker.window_base + $urandom_range(1, 4);
            else
               seq = tracker.window_base + $urandom_range(1, ws + 2);
         end else if (pick < 75) begin
            seq = tracker.window_base - $urandom_range(1, 6);
         end else if (pick < 79) begin
            kind = srrw_pkg::PKT_END;
            seq  = tracker.session_id;
         end else if (pick < 83) begin
            kind = srrw_pkg::PKT_END;
         end else if (pick < 87) begin
            kind = srrw_pkg::PKT_START;
         end else if (pick < 91) begin
            kind = srrw_pkg::PKT_OTHER;
         end else if (pick < 95) begin
            kind = srrw_pkg::pkt_type_type'($urandom_range(0, 3));
            ok   = 1'b0;
         end
         send_header(kind, seq, ok);
      end
   endtask

   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset window size.
      send_header(srrw_pkg::PKT_DATA,  32'd5,        1'b1);   // data with no session
      send_header(srrw_pkg::PKT_END,   32'd0,        1'b1);   // end with no session
      send_header(srrw_pkg::PKT_OTHER, 32'hFFFFFFFF, 1'b1);   // unknown type
      send_header(srrw_pkg::PKT_START, 32'd0,        1'b0);   // bad checksum on start
      send_header(srrw_pkg::PKT_START, 32'hFFFFFFFF, 1'b1);   // open the session
      send_header(srrw_pkg::PKT_START, 32'd7,        1'b1);   // redundant start
      send_header(srrw_pkg::PKT_END,   32'd0,        1'b1);   // end number mismatch
      send_header(srrw_pkg::PKT_DATA,  32'd0,        1'b0);   // bad checksum on data
      send_header(srrw_pkg::PKT_DATA,  32'd2,        1'b1);   // store above base
      send_header(srrw_pkg::PKT_DATA,  32'd2,        1'b1);   // duplicate, no store
      send_header(srrw_pkg::PKT_DATA,  32'd64,       1'b1);   // just past the window
      send_header(srrw_pkg::PKT_DATA,  32'd63,       1'b1);   // last slot of the window
      send_header(srrw_pkg::PKT_DATA,  32'hFFFFFFFF, 1'b1);   // far above the window
      send_header(srrw_pkg::PKT_DATA,  32'd0,        1'b1);   // fill base, slide by one
      send_header(srrw_pkg::PKT_DATA,  32'd1,        1'b1);   // fill base, slide past 2
      send_header(srrw_pkg::PKT_DATA,  32'd0,        1'b1);   // below base
      send_header(srrw_pkg::PKT_OTHER, 32'd0,        1'b0);   // bad checksum, unknown
      send_header(srrw_pkg::PKT_END,   32'hFFFFFFFF, 1'b1);   // matching end
      send_header(srrw_pkg::PKT_END,   32'hFFFFFFFF, 1'b1);   // end after close
      send_header(srrw_pkg::PKT_START, 32'd0,        1'b1);
      send_header(srrw_pkg::PKT_DATA,  32'd0,        1'b1);
      send_header(srrw_pkg::PKT_END,   32'd0,        1'b1);

      // Random phases across window sizes, saturating values included.
      run_phase(7'd127, 160);
      run_phase(7'd1,   160);
      run_phase(7'd0,   140);
      run_phase(7'd64,  180);
      run_phase(7'd9,   180);
      run_phase(7'd33,  180);
      idle_enable = 1'b0;
      run_phase(7'd5,   200);

      req_tvalid <= 1'b0;
      while (tracker.pending_acks.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_acks.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
